### rtl/assert_macros.svh
// Assertion helpers used by spf_byte_seq. They vanish in synthesis builds.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define ASSERT_CLK(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("assertion failed");
`define ASSERT_NEVER(lbl, clk, rst_n, cond) `ASSERT_CLK(lbl, clk, rst_n, !(cond))
`else
`define ASSERT_CLK(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif

`endif

### rtl/spf_pkg.sv
package spf_pkg;

	localparam logic [15:0] CRC_POLY = 16'h8005;
	localparam logic [15:0] CRC_INIT = 16'h0000;
	localparam logic [7:0]  HDR_SYNC = 8'hFF;
	localparam logic [7:0]  HDR_MARK = 8'hFD;
	localparam logic [7:0]  HDR_RSVD = 8'h00;
	localparam logic [8:0]  LEN_EXTRA = 9'd3;

	// Byte positions inside the start sequence.
	localparam logic [3:0] POS_SYNC0  = 4'd0;
	localparam logic [3:0] POS_SYNC1  = 4'd1;
	localparam logic [3:0] POS_MARK   = 4'd2;
	localparam logic [3:0] POS_RSVD   = 4'd3;
	localparam logic [3:0] POS_ID     = 4'd4;
	localparam logic [3:0] POS_LEN_LO = 4'd5;
	localparam logic [3:0] POS_LEN_HI = 4'd6;
	localparam logic [3:0] POS_INSTR  = 4'd7;
	localparam logic [3:0] POS_CRC_LO = 4'd8;
	localparam logic [3:0] POS_CRC_HI = 4'd9;

	// Byte positions inside a parameter sequence.
	localparam logic [3:0] PPOS_DATA   = 4'd0;
	localparam logic [3:0] PPOS_CRC_LO = 4'd1;
	localparam logic [3:0] PPOS_CRC_HI = 4'd2;

	typedef enum logic [1:0] {
		BK_DATA,
		BK_CRC_LO,
		BK_CRC_HI
	} byte_kind_t;

	typedef struct packed {
		logic       start;
		logic [7:0] servo_id;
		logic [7:0] instruction;
		logic [7:0] param_count;
		logic [7:0] param_byte;
	} item_t;

	typedef struct packed {
		logic [7:0] tx_byte;
		logic       last_byte;
	} word_t;

	function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {b, 8'h00};
		for (int k = 0; k < 8; k++) begin
			c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
		end
		return c;
	endfunction

endpackage

### rtl/servo_packet_framer_crc16.sv
// Path: a word is taken into the input register, then its bytes go into the
// output queue, whose head shows on m_tdata. One byte per cycle unless the queue
// is full. A parameter word yields one byte, the last one three (data and CRC);
// a start word yields eight bytes, ten with a zero count.
// Reset: arst_n clears the CRC, the pending count and all valid flags at once.
module servo_packet_framer_crc16
	import spf_pkg::*;
#(
	parameter int MAX_PARAMS = 255
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// [7:0] servo_id, [15:8] instruction, [23:16] param_count, [31:24] param_byte
	input  logic [31:0] s_tdata,
	// [0] start_req
	input  logic [0:0]  s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// [7:0] tx_byte
	output logic [7:0]  m_tdata,
	output logic        m_tlast
);

	logic  valid_s1;
	item_t item_s1;
	logic  consume;
	logic  seq_valid;
	word_t seq_word;
	logic  fifo_ready;
	word_t out_word;

	assign s_tready = !valid_s1 || consume;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			item_s1 <= '{start: s_tuser[0], servo_id: s_tdata[7:0],
				instruction: s_tdata[15:8], param_count: s_tdata[23:16],
				param_byte: s_tdata[31:24]};
		end
	end

	spf_byte_seq #(
		.MAX_PARAMS(MAX_PARAMS)
	) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.item_valid(valid_s1),
		.item      (item_s1),
		.consume   (consume),
		.word_valid(seq_valid),
		.word      (seq_word),
		.out_ready (fifo_ready)
	);

	spf_out_fifo u_out (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_valid(seq_valid),
		.wr_word (seq_word),
		.wr_ready(fifo_ready),
		.rd_valid(m_tvalid),
		.rd_word (out_word),
		.rd_ready(m_tready)
	);

	assign m_tdata = out_word.tx_byte;
	assign m_tlast = out_word.last_byte;

endmodule

### rtl/spf_byte_seq.sv
`include "assert_macros.svh"

module spf_byte_seq
	import spf_pkg::*;
#(
	parameter int MAX_PARAMS = 255
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  item_valid,
	input  item_t item,
	output logic  consume,
	output logic  word_valid,
	output word_t word,
	input  logic  out_ready
);

	localparam logic [7:0] MaxCnt = 8'(MAX_PARAMS);

	logic [3:0]  idx_q;
	logic [15:0] crc_q;
	logic [7:0]  params_left_q;

	logic [7:0]  cnt_sat;
	logic [8:0]  len;
	logic [7:0]  byte_c;
	byte_kind_t  kind_c;
	logic        final_c;
	logic        drop_c;
	logic        emit_c;
	logic [15:0] crc_base;

	always_comb begin
		cnt_sat = (item.param_count > MaxCnt) ? MaxCnt : item.param_count;
		len     = {1'b0, cnt_sat} + LEN_EXTRA;
		byte_c  = 8'h00;
		kind_c  = BK_DATA;
		final_c = 1'b0;
		if (item.start) begin
			unique case (idx_q)
				POS_SYNC0:  byte_c = HDR_SYNC;
				POS_SYNC1:  byte_c = HDR_SYNC;
				POS_MARK:   byte_c = HDR_MARK;
				POS_RSVD:   byte_c = HDR_RSVD;
				POS_ID:     byte_c = item.servo_id;
				POS_LEN_LO: byte_c = len[7:0];
				POS_LEN_HI: byte_c = {7'd0, len[8]};
				POS_INSTR:  byte_c = item.instruction;
				POS_CRC_LO: begin
					byte_c = crc_q[7:0];
					kind_c = BK_CRC_LO;
				end
				POS_CRC_HI: begin
					byte_c = crc_q[15:8];
					kind_c = BK_CRC_HI;
				end
				default:    byte_c = 8'h00;
			endcase
			final_c = (idx_q == POS_INSTR && cnt_sat != 8'd0) || idx_q == POS_CRC_HI;
		end else begin
			unique case (idx_q)
				PPOS_DATA:   byte_c = item.param_byte;
				PPOS_CRC_LO: begin
					byte_c = crc_q[7:0];
					kind_c = BK_CRC_LO;
				end
				PPOS_CRC_HI: begin
					byte_c = crc_q[15:8];
					kind_c = BK_CRC_HI;
				end
				default:     byte_c = 8'h00;
			endcase
			final_c = (idx_q == PPOS_DATA && params_left_q != 8'd1) || idx_q == PPOS_CRC_HI;
		end
	end

	// A parameter word with no packet open is swallowed without output.
	assign drop_c     = item_valid && !item.start && idx_q == PPOS_DATA && params_left_q == 8'd0;
	assign word_valid = item_valid && !drop_c;
	assign emit_c     = word_valid && out_ready;
	assign consume    = drop_c || (emit_c && final_c);
	assign word       = '{tx_byte: byte_c, last_byte: (kind_c == BK_CRC_HI)};
	assign crc_base   = (item.start && idx_q == POS_SYNC0) ? CRC_INIT : crc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q         <= 4'd0;
			crc_q         <= CRC_INIT;
			params_left_q <= 8'd0;
		end else if (emit_c) begin
			idx_q <= final_c ? 4'd0 : idx_q + 4'd1;
			unique case (kind_c)
				BK_DATA:   crc_q <= crc_byte(crc_base, byte_c);
				BK_CRC_LO: crc_q <= crc_q;
				BK_CRC_HI: crc_q <= CRC_INIT;
				default:   crc_q <= crc_q;
			endcase
			if (idx_q == 4'd0) begin
				params_left_q <= item.start ? cnt_sat : params_left_q - 8'd1;
			end
		end
	end

	`ASSERT_CLK(a_crc_clear, clk, arst_n, emit_c && kind_c == BK_CRC_HI |=> crc_q == CRC_INIT)
	`ASSERT_CLK(a_idx_wrap, clk, arst_n, consume |=> idx_q == 4'd0)
	`ASSERT_NEVER(a_no_stray, clk, arst_n, drop_c && emit_c)
	`ASSERT_CLK(a_last_pos, clk, arst_n, word_valid && word.last_byte |-> final_c)

endmodule

### rtl/spf_out_fifo.sv
module spf_out_fifo
	import spf_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  wr_valid,
	input  word_t wr_word,
	output logic  wr_ready,
	output logic  rd_valid,
	output word_t rd_word,
	input  logic  rd_ready
);

	word_t      mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;
	logic       push;
	logic       pop;

	assign wr_ready = (cnt_q != 2'd2);
	assign rd_valid = (cnt_q != 2'd0);
	assign rd_word  = mem_q[rd_ptr_q];
	assign push     = wr_valid && wr_ready;
	assign pop      = rd_valid && rd_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

endmodule

### verif/servo_packet_framer_crc16_test.sv
module servo_packet_framer_crc16_test;
	timeunit 1ns;
	timeprecision 1ps;

	import spf_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int DRAIN_CYCLES = 8;
	localparam int HOLD_CYCLES = 300;

	// Predicts the framed byte stream and checks the bytes that leave the block.
	class frame_predictor;
		logic [15:0] crc;
		logic [7:0]  params_left;
		word_t       expected_bytes[$];
		int          mismatches;
		int          bytes_checked;

		function void clear();
			crc = CRC_INIT;
			params_left = '0;
			expected_bytes.delete();
			mismatches = 0;
			bytes_checked = 0;
		endfunction

		function logic [15:0] crc16_update(logic [15:0] c, logic [7:0] b);
			logic fb;
			for (int i = 7; i >= 0; i--) begin
				fb = c[15] ^ b[i];
				c = {c[14:0], 1'b0};
				if (fb)
					c = c ^ CRC_POLY;
			end
			return c;
		endfunction

		function void push_byte(logic [7:0] b, logic last, bit in_crc);
			word_t w;
			w.tx_byte = b;
			w.last_byte = last;
			expected_bytes.push_back(w);
			if (in_crc)
				crc = crc16_update(crc, b);
		endfunction

		function void push_crc();
			logic [15:0] c;
			c = crc;
			push_byte(c[7:0], 1'b0, 1'b0);
			push_byte(c[15:8], 1'b1, 1'b0);
			crc = CRC_INIT;
		endfunction

		// Returns the number of bytes the word produces; zero means it was dropped.
		function int note_word(logic start, logic [7:0] id, logic [7:0] instr,
			logic [7:0] count, logic [7:0] pb);
			logic [8:0] len;
			int before_size;
			before_size = expected_bytes.size();
			if (start) begin
				len = {1'b0, count} + LEN_EXTRA;
				crc = CRC_INIT;
				push_byte(HDR_SYNC, 1'b0, 1'b1);
				push_byte(HDR_SYNC, 1'b0, 1'b1);
				push_byte(HDR_MARK, 1'b0, 1'b1);
				push_byte(HDR_RSVD, 1'b0, 1'b1);
				push_byte(id, 1'b0, 1'b1);
				push_byte(len[7:0], 1'b0, 1'b1);
				push_byte({7'b0, len[8]}, 1'b0, 1'b1);
				push_byte(instr, 1'b0, 1'b1);
				params_left = count;
				if (count == 8'd0)
					push_crc();
			end else if (params_left != 8'd0) begin
				push_byte(pb, 1'b0, 1'b1);
				params_left = params_left - 8'd1;
				if (params_left == 8'd0)
					push_crc();
			end
			return expected_bytes.size() - before_size;
		endfunction

		function void report(string msg);
			mismatches++;
			if (mismatches <= 10)
				$display("%0t: %s", $realtime, msg);
		endfunction

		function void check_word(logic [7:0] b, logic last);
			word_t w;
			bytes_checked++;
			if (expected_bytes.size() == 0) begin
				report($sformatf("unexpected byte %02h last %0b", b, last));
				return;
			end
			w = expected_bytes.pop_front();
			if (b !== w.tx_byte)
				report($sformatf("tx_byte expected %02h actual %02h", w.tx_byte, b));
			if (last !== w.last_byte)
				report($sformatf("last_byte expected %0b actual %0b", w.last_byte, last));
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [31:0] s_tdata = '0;
	logic [0:0]  s_tuser = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [7:0]  m_tdata;
	logic        m_tlast;

	frame_predictor sb = new();

	int idle_pct = 0;
	int stall_pct = 0;
	int hold_left = 0;
	int cycles = 0;
	int words_sent = 0;
	int packets_sent = 0;
	int packets_cut = 0;
	int strays_sent = 0;

	servo_packet_framer_crc16 DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Receiver: random stalls, or a long hold-off when one is requested.
	initial begin
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				m_tready <= 1'b0;
				hold_left--;
			end else begin
				m_tready <= ($urandom_range(0, 99) >= stall_pct);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.check_word(m_tdata, m_tlast);
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles", cycles);
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// Called at a falling edge; returns at the falling edge after the word is taken.
	task automatic send_word(logic start, logic [7:0] id, logic [7:0] instr,
		logic [7:0] count, logic [7:0] pb);
		while ($urandom_range(0, 99) < idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= start;
		s_tdata <= {pb, count, instr, id};
		do
			@(posedge clk);
		while (!s_tready);
		void'(sb.note_word(start, id, instr, count, pb));
		words_sent++;
		@(negedge clk);
	endtask

	// The unused fields carry random values, since the block must ignore them.
	task automatic send_start(logic [7:0] id, logic [7:0] instr, logic [7:0] count);
		send_word(1'b1, id, instr, count, 8'($urandom));
		packets_sent++;
	endtask

	task automatic send_param(logic [7:0] pb);
		if (sb.params_left == 8'd0)
			strays_sent++;
		send_word(1'b0, 8'($urandom), 8'($urandom), 8'($urandom), pb);
	endtask

	task automatic send_packet(logic [7:0] count, int nparams);
		send_start(8'($urandom), 8'($urandom), count);
		for (int i = 0; i < nparams; i++)
			send_param(8'($urandom));
		if (nparams < count)
			packets_cut++;
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (sb.expected_bytes.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic run_random(int target);
		int n;
		int cnt;
		int nparams;
		n = 0;
		while (n < target) begin
			if ($urandom_range(0, 99) < 6 && sb.params_left == 8'd0) begin
				send_param(8'($urandom));
			end else begin
				cnt = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 40)
					: $urandom_range(0, 7);
				// About one packet in ten is cut short and restarted by the next start.
				nparams = ($urandom_range(0, 9) == 0) ? $urandom_range(0, cnt) : cnt;
				send_packet(8'(cnt), nparams);
				n += 1 + nparams;
			end
		end
	endtask

	initial begin
		sb.clear();
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed words with both sides always ready.
		send_param(8'hA5);
		send_start(8'h00, 8'h00, 8'h00);
		send_start(8'hFF, 8'hFF, 8'h00);
		send_start(8'h01, 8'h02, 8'h01);
		send_param(8'hFF);
		send_start(8'h7E, 8'h03, 8'h02);
		send_param(8'h00);
		send_param(8'h5A);
		send_start(8'h10, 8'h55, 8'h03);
		send_param(8'h11);
		packets_cut++;
		send_start(8'hFE, 8'h80, 8'h01);
		send_param(8'h80);
		send_param(8'h7F);
		wait_drained();

		// Long receiver hold-off while a full-size packet keeps arriving.
		hold_left = HOLD_CYCLES;
		send_packet(8'hFF, 255);
		wait_drained();

		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin idle_pct = 0;  stall_pct = 0;  end
				1: begin idle_pct = 73; stall_pct = 0;  end
				2: begin idle_pct = 0;  stall_pct = 73; end
				default: begin idle_pct = 34; stall_pct = 34; end
			endcase
			run_random(33);
			wait_drained();
		end

		$display("Sent %0d words in %0d packets (%0d cut short, %0d stray words).",
			words_sent, packets_sent, packets_cut, strays_sent);
		$display("Checked %0d output bytes, %0d mismatches.",
			sb.bytes_checked, sb.mismatches);
		if (sb.mismatches == 0 && sb.expected_bytes.size() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
